// ===== sv/b32d_pkg.sv =====
// Package for the permuted-alphabet base32 decoder.
// Holds the symbol codes, the alphabet lookup, the job record and the queue sizing.
// No dependencies.
package b32d_pkg;

  localparam int unsigned QDepth = 8;
  localparam int unsigned QAw    = $clog2(QDepth);

  localparam logic [5:0] SYM_PAD = 6'd32;
  localparam logic [5:0] SYM_BAD = 6'd33;

  localparam int unsigned BytesPerGroup = 5;
  localparam int unsigned SymsPerGroup  = 8;

  // One decode job: the bytes of a completed group, or a single error beat.
  typedef struct packed {
    logic [BytesPerGroup-1:0][7:0] bytes;
    logic [2:0]                    count;
    logic                          last;
    logic                          err;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic empty;
    job_t head;
  } q_rd_t;

  // Maps an ASCII code to its symbol value; padding gives SYM_PAD and
  // anything outside the alphabet gives SYM_BAD.
  function automatic logic [5:0] sym_of(input logic [7:0] ch);
    logic [5:0] v;
    case (ch)
      8'h4D:   v = 6'd0;
      8'h42:   v = 6'd1;
      8'h4A:   v = 6'd2;
      8'h59:   v = 6'd3;
      8'h41:   v = 6'd4;
      8'h33:   v = 6'd5;
      8'h5A:   v = 6'd6;
      8'h37:   v = 6'd7;
      8'h35:   v = 6'd8;
      8'h50:   v = 6'd9;
      8'h53:   v = 6'd10;
      8'h34:   v = 6'd11;
      8'h3D:   v = 6'd12;
      8'h4E:   v = 6'd13;
      8'h58:   v = 6'd14;
      8'h51:   v = 6'd15;
      8'h32:   v = 6'd16;
      8'h44:   v = 6'd17;
      8'h55:   v = 6'd18;
      8'h52:   v = 6'd19;
      8'h49:   v = 6'd20;
      8'h54:   v = 6'd21;
      8'h57:   v = 6'd22;
      8'h4B:   v = 6'd23;
      8'h36:   v = 6'd24;
      8'h48:   v = 6'd25;
      8'h47:   v = 6'd26;
      8'h4C:   v = 6'd27;
      8'h46:   v = 6'd28;
      8'h45:   v = 6'd29;
      8'h43:   v = 6'd30;
      8'h56:   v = 6'd31;
      8'h4F:   v = SYM_PAD;
      default: v = SYM_BAD;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/b32d_in_if.sv =====
// Input channel of the base32 decoder: one character beat with an end flag.
// No dependencies.
interface b32d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       msg_end;

  modport source(output valid, in_char, msg_end, input ready);
  modport sink(input valid, in_char, msg_end, output ready);
endinterface

// ===== sv/b32d_out_if.sv =====
// Result channel of the base32 decoder: one decoded byte beat with flags.
// No dependencies.
interface b32d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       error;
  logic       final_res;

  modport source(output valid, out_byte, error, final_res, input ready);
  modport sink(input valid, out_byte, error, final_res, output ready);
endinterface

// ===== sv/b32d_front.sv =====
// Front end: classifies characters, assembles groups of eight symbols and
// pushes one job per completed group or per fault. Depends on b32d_pkg.
module b32d_front
  import b32d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_char,
  input  logic       in_msg_end,
  input  logic       q_full,
  output logic       in_ready,
  output q_wr_t      q_wr
);

  logic [2:0] pos_r, pos_nxt;
  logic       drop_r, drop_nxt;
  logic [5:0] sym_r [SymsPerGroup-1];

  logic       accept;
  logic [5:0] v;
  logic       fault;
  logic [2:0] cnt;
  logic [5:0] s7;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign v        = sym_of(in_char);
  assign s7       = v;

  assign fault = (v == SYM_BAD) || ((v == SYM_PAD) && (pos_r < 3'd2)) ||
                 (in_msg_end && (pos_r != 3'd7));

  // Nested padding rule on positions eight, six, five and three.
  always_comb begin
    cnt = 3'd5;
    if (s7 == SYM_PAD) begin
      cnt = 3'd4;
      if (sym_r[5] == SYM_PAD) begin
        cnt = 3'd3;
        if (sym_r[4] == SYM_PAD) begin
          cnt = 3'd2;
          if (sym_r[2] == SYM_PAD) begin
            cnt = 3'd1;
          end
        end
      end
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    drop_nxt = drop_r;
    q_wr     = '0;
    if (accept) begin
      if (drop_r) begin
        if (in_msg_end) begin
          drop_nxt = 1'b0;
          pos_nxt  = 3'd0;
        end
      end else if (fault) begin
        q_wr.push     = 1'b1;
        q_wr.job.err  = 1'b1;
        q_wr.job.last = 1'b1;
        q_wr.job.count = 3'd1;
        pos_nxt  = 3'd0;
        drop_nxt = !in_msg_end;
      end else begin
        pos_nxt = pos_r + 3'd1;
        if (pos_r == 3'd7) begin
          q_wr.push      = 1'b1;
          q_wr.job.last  = in_msg_end;
          q_wr.job.count = cnt;
          q_wr.job.bytes[0] = {sym_r[0][4:0], sym_r[1][4:2]};
          q_wr.job.bytes[1] = {sym_r[1][1:0], sym_r[2][4:0], sym_r[3][4]};
          q_wr.job.bytes[2] = {sym_r[3][3:0], sym_r[4][4:1]};
          q_wr.job.bytes[3] = {sym_r[4][0], sym_r[5][4:0], sym_r[6][4:3]};
          q_wr.job.bytes[4] = {sym_r[6][2:0], s7[4:0]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 3'd0;
      drop_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      drop_r <= drop_nxt;
    end
  end

  // Symbol store; position eight is used straight from the input.
  always_ff @(posedge clk) begin
    if (accept && !drop_r && !fault && (pos_r != 3'd7)) begin
      sym_r[pos_r] <= v;
    end
  end

endmodule

// ===== sv/b32d_queue.sv =====
// Short job queue between the front and back ends of the decoder.
// Depends on b32d_pkg.
module b32d_queue
  import b32d_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  input  logic  pop,
  output logic  full,
  output q_rd_t q_rd
);

  job_t           mem [QDepth];
  logic [QAw-1:0] wp_r, wp_nxt;
  logic [QAw-1:0] rp_r, rp_nxt;
  logic [QAw:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full       = (cnt_r == (QAw+1)'(QDepth));
  assign q_rd.empty = (cnt_r == '0);
  assign q_rd.head  = mem[rp_r];

  assign do_push = q_wr.push && !full;
  assign do_pop  = pop && !q_rd.empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= q_wr.job;
    end
  end

endmodule

// ===== sv/b32d_back.sv =====
// Back end: walks the head job into the output register one byte per cycle
// while that register is free or taken by the receiver. Depends on b32d_pkg.
module b32d_back
  import b32d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_rd_t      q_rd,
  output logic       pop,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_error,
  output logic       out_final
);

  logic [2:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] byte_r;
  logic       err_r, fin_r;
  logic       load, take, at_end;

  assign load   = !ov_r || out_ready;
  assign take   = load && !q_rd.empty;
  assign at_end = ((idx_r + 3'd1) == q_rd.head.count);
  assign pop    = take && at_end;

  always_comb begin
    idx_nxt = idx_r;
    ov_nxt  = ov_r;
    if (load) begin
      ov_nxt = !q_rd.empty;
    end
    if (take) begin
      idx_nxt = at_end ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= q_rd.head.bytes[idx_r];
      err_r  <= q_rd.head.err;
      fin_r  <= q_rd.head.last && at_end;
    end
  end

  assign out_valid = ov_r;
  assign out_byte  = byte_r;
  assign out_error = err_r;
  assign out_final = fin_r;

endmodule

// ===== sv/base32_decoder_custom_alphabet_top.sv =====
// Top level of the permuted-alphabet base32 decoder.
// Depends on b32d_pkg, b32d_in_if, b32d_out_if, b32d_front, b32d_queue, b32d_back.
//
// Usage: characters arrive on in_ch, one beat per character, with msg_end set
// on the last character of a message. Decoded bytes leave on out_ch, one beat
// per byte, with error set on a fault beat and final_res set on the last beat
// of a message. A group of eight characters yields one to five bytes.
// An invalid character, padding in the first two positions of a group, or a
// message that ends inside a group yields a single error beat; the remaining
// characters of that message are accepted and ignored.
// Throughput: one character per cycle, and one result beat per cycle while
// the receiver is ready. A character is accepted whenever the eight-entry
// job queue has room. A full group followed by a run of one-character error
// messages keeps at most five jobs queued, so the input only stalls when the
// receiver has held off. The job of a group is written into the queue when
// its eighth character is accepted, and the output register then loads its
// first byte from the queue head; the others follow one per cycle while the
// receiver takes them. Reset clears the group position, the drop state, the
// queue and the output valid; no clearing pass is needed. While the receiver
// stalls, the output register holds its beat and the queue absorbs further jobs.
module base32_decoder_custom_alphabet_top
  import b32d_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  b32d_in_if.sink     in_ch,
  b32d_out_if.source  out_ch
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Front end: character lookup, group assembly and fault detection.
  b32d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_char    (in_ch.in_char),
    .in_msg_end (in_ch.msg_end),
    .q_full     (q_full),
    .in_ready   (in_ch.ready),
    .q_wr       (q_wr)
  );

  // Job queue decouples character intake from byte emission.
  b32d_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  // Back end: one byte per cycle into the registered output while not stalled.
  b32d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .pop       (q_pop),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_error (out_ch.error),
    .out_final (out_ch.final_res)
  );

endmodule
